@@ rtl/rcds_pkg.sv @@
package rcds_pkg;

    // Field widths fixed by the cell and register formats
    localparam int DIST_W     = 48;
    localparam int FRIC_W     = 32;
    localparam int STEP_W     = 32;
    localparam int COLS_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Defaults for the top-level parameters
    localparam int MAX_COLS_DEF  = 4096;
    localparam int FRAC_BITS_DEF = 16;

    // Stream packing
    localparam int S_TDATA_W  = 88;
    localparam int S_FV_BIT   = 32;
    localparam int S_PD_LSB   = 33;
    localparam int S_PV_BIT   = 81;
    localparam int M_TDATA_W  = 56;
    localparam int M_NV_BIT   = 48;
    localparam int M_NEG_BIT  = 49;
    localparam int M_USED_W   = 50;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DIAG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CODE = 3'd5;

    // Register reset values
    localparam logic [COLS_W-1:0] COLUMNS_RST   = 13'd256;
    localparam logic [STEP_W-1:0] STEP_X_RST    = 32'd65536;
    localparam logic [STEP_W-1:0] STEP_Y_RST    = 32'd65536;
    localparam logic [STEP_W-1:0] STEP_DIAG_RST = 32'd92682;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Friction sum split into sign and magnitude
    typedef struct packed {
        logic              neg;
        logic [FRIC_W:0]   mag;
    } smag_t;

    // Edge cost, magnitude clamped at 2^48
    typedef struct packed {
        logic              neg;
        logic [DIST_W:0]   mag;
    } cost_t;

    // Candidate distance with its usable flag
    typedef struct packed {
        logic              ok;
        logic [DIST_W-1:0] d;
    } cand_t;

    function automatic smag_t to_smag(input logic [FRIC_W:0] s);
        smag_t r;
        r.neg = s[FRIC_W];
        r.mag = s[FRIC_W] ? (~s + {{FRIC_W{1'b0}}, 1'b1}) : s;
        return r;
    endfunction

    // Neighbour distance plus edge, saturated to [0, DIST_MAX]
    function automatic logic [DIST_W-1:0] cand_dist(input logic [DIST_W-1:0] d,
                                                    input cost_t e);
        logic [DIST_W+1:0] sum;
        logic [DIST_W-1:0] r;
        sum = {2'b00, d} + {1'b0, e.mag};
        if (e.neg) begin
            r = (e.mag > {1'b0, d}) ? '0 : d - e.mag[DIST_W-1:0];
        end else begin
            r = (sum > {2'b00, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
        end
        return r;
    endfunction

    function automatic cand_t cand_min(input cand_t a, input cand_t b);
        cand_t r;
        if (!a.ok) begin
            r = b;
        end else if (!b.ok) begin
            r = a;
        end else begin
            r = (b.d < a.d) ? b : a;
        end
        return r;
    endfunction

endpackage

@@ rtl/raster_cost_distance_sweep_core.sv @@
// Raster cost-distance sweep: takes one raster cell per clock in row-major order and
// returns its updated distance from a registered output, sustaining one cell per cycle;
// s_tready drops only while a finished result waits on m_tready, and then the
// whole pipeline holds. The row above lives in a single line memory of MAX_COLS entries
// (distance, friction, usable flag) with one read port, used when a cell is taken, and
// one write port, used when its result is formed; short rows and restarted frames that
// hit an entry still in flight are served by forwarding from the pipeline, so there is
// no clearing pass and the block is ready straight after reset. Entries read before they
// were ever written return whatever the memory holds. Stages: accept and line read,
// friction sums, 32x32 edge multiplies, scaling and clamping, then the neighbour adds and
// four-way minimum, the only stage that feeds back (to the left, upper-left and upper).
// Configuration is taken every cycle and must only change while the block is idle.
module raster_cost_distance_sweep_core #(
    parameter int MAX_COLS  = rcds_pkg::MAX_COLS_DEF,
    parameter int FRAC_BITS = rcds_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // friction[31:0], friction_valid[32], prior_dist[80:33], prior_valid[81], zero pad
    input  logic [rcds_pkg::S_TDATA_W-1:0]   s_tdata,
    // frame_start[0]
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // new_dist[47:0], new_valid[48], neg_friction[49], zero pad
    output logic [rcds_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rcds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcds_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rcds_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CMP_W  = (COL_W + 1 > COLS_W) ? COL_W + 1 : COLS_W;
    localparam int MEM_W  = DIST_W + FRIC_W + 1;
    localparam int SUM_W  = FRIC_W + 1;
    localparam int PROD_W = 2 * STEP_W;

    typedef struct packed {
        logic [FRIC_W-1:0] f;
        logic              fv;
        logic [DIST_W-1:0] pd;
        logic              pv;
        logic              neg;
        logic [COL_W-1:0]  col;
        logic              fr;
    } cell_t;

    typedef struct packed {
        logic [DIST_W-1:0] d;
        logic              v;
    } upd_t;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] p;
    } prod_t;

    // Configuration registers
    logic [COLS_W-1:0]  columns_reg;
    logic [STEP_W-1:0]  step_x_reg, step_y_reg, step_diag_reg;
    logic               grid_reg;
    logic [FRIC_W-1:0]  target_reg;

    // Control
    logic               en, acc;
    logic               v1_reg, v2_reg, v3_reg, v4_reg, m_tvalid_reg;
    logic [COL_W-1:0]   col_reg, col_in, col_next;
    logic               fr_reg, fr_in, fr_next, wrap;
    logic [CMP_W-1:0]   cols_eff;

    // Input decode
    logic [FRIC_W-1:0]  in_f, f_st_in;
    logic               in_fv, in_pv, neg_in;
    logic [DIST_W-1:0]  in_pd;
    logic [SUM_W-1:0]   sl_in;
    cell_t              cell_in;

    // Neighbour state
    logic [FRIC_W-1:0]  left_f_reg, lastupf_reg;
    logic [DIST_W-1:0]  left_d_reg, diag_d_reg;
    logic               left_v_reg, diag_v_reg;

    // Line memory
    logic [MEM_W-1:0]   line_mem [MAX_COLS];
    logic [MEM_W-1:0]   rd_q_reg;
    logic               wr_en;

    // Pipeline
    cell_t              p1_cell_reg, p2_cell_reg, p3_cell_reg, p4_cell_reg;
    logic [SUM_W-1:0]   p1_sl_reg;
    logic               p1_hit_reg;
    upd_t               p1_cap_reg;
    logic [FRIC_W-1:0]  p1_capf_reg;
    upd_t               p2_up_reg, p3_up_reg, p4_up_reg;
    smag_t              p2_sml_reg, p2_smu_reg, p2_smd_reg;
    prod_t              p3_prl_reg, p3_pru_reg, p3_prd_reg;
    cost_t              p4_cl_reg, p4_cu_reg, p4_cd_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic               cap_acc, cap1, cap2, cap3;
    logic [FRIC_W-1:0]  up_f_s1;
    upd_t               up_s1, wr_up;
    logic [SUM_W-1:0]   su_s1, sd_s1;
    prod_t              prl_s2, pru_s2, prd_s2;
    cost_t              cl_s3, cu_s3, cd_s3;
    cand_t              cp, cl, cu, cd, cbest;
    logic               col_nz;
    logic [DIST_W-1:0]  wr_best;
    logic               wr_usable;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg   <= COLUMNS_RST;
            step_x_reg    <= STEP_X_RST;
            step_y_reg    <= STEP_Y_RST;
            step_diag_reg <= STEP_DIAG_RST;
            grid_reg      <= 1'b0;
            target_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_COLUMNS:     columns_reg   <= cfg_data[COLS_W-1:0];
                CFG_STEP_X:      step_x_reg    <= cfg_data[STEP_W-1:0];
                CFG_STEP_Y:      step_y_reg    <= cfg_data[STEP_W-1:0];
                CFG_STEP_DIAG:   step_diag_reg <= cfg_data[STEP_W-1:0];
                CFG_GRID_MODE:   grid_reg      <= cfg_data[0];
                CFG_TARGET_CODE: target_reg    <= cfg_data[FRIC_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: whole pipeline moves when the output slot frees
    // ---------------------------------------------------------------
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && aresetn;
    assign acc      = s_tvalid && s_tready;
    assign wr_en    = en && v4_reg;

    // ---------------------------------------------------------------
    // Accept: decode, column tracking, left friction sum
    // ---------------------------------------------------------------
    assign in_f  = s_tdata[FRIC_W-1:0];
    assign in_fv = s_tdata[S_FV_BIT];
    assign in_pd = s_tdata[S_PD_LSB +: DIST_W];
    assign in_pv = s_tdata[S_PV_BIT];

    // target cells count as zero friction
    assign f_st_in = (in_fv && (in_f == target_reg)) ? '0 : in_f;
    assign neg_in  = in_fv && !grid_reg && f_st_in[FRIC_W-1];
    assign sl_in   = {f_st_in[FRIC_W-1], f_st_in} + {left_f_reg[FRIC_W-1], left_f_reg};

    always_comb begin
        if (columns_reg == '0) begin
            cols_eff = CMP_W'(1);
        end else if (CMP_W'(columns_reg) > CMP_W'(MAX_COLS)) begin
            cols_eff = CMP_W'(MAX_COLS);
        end else begin
            cols_eff = CMP_W'(columns_reg);
        end
    end

    assign col_in   = s_tuser[0] ? '0 : col_reg;
    assign fr_in    = s_tuser[0] | fr_reg;
    assign wrap     = (CMP_W'(col_in) + CMP_W'(1)) >= cols_eff;
    assign col_next = wrap ? '0 : col_in + COL_W'(1);
    assign fr_next  = wrap ? 1'b0 : fr_in;

    always_comb begin
        cell_in.f   = f_st_in;
        cell_in.fv  = in_fv;
        cell_in.pd  = in_pd;
        cell_in.pv  = in_pv;
        cell_in.neg = neg_in;
        cell_in.col = col_in;
        cell_in.fr  = fr_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            fr_reg     <= 1'b1;
            left_f_reg <= '0;
        end else if (acc) begin
            col_reg    <= col_next;
            fr_reg     <= fr_next;
            left_f_reg <= f_st_in;
        end
    end

    // ---------------------------------------------------------------
    // Line memory: read on transfer in, write when a result forms
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[p4_cell_reg.col] <= {wr_usable, p4_cell_reg.f, wr_best};
        end
        if (en) begin
            rd_q_reg <= line_mem[col_in];
        end
    end

    // results landing at the same column as a younger cell overtake the stored entry
    assign wr_up.d = wr_best;
    assign wr_up.v = wr_usable;
    assign cap_acc = v4_reg && (p4_cell_reg.col == col_in);
    assign cap1    = v4_reg && (p4_cell_reg.col == p1_cell_reg.col) && !p1_cell_reg.fr;
    assign cap2    = v4_reg && (p4_cell_reg.col == p2_cell_reg.col) && !p2_cell_reg.fr;
    assign cap3    = v4_reg && (p4_cell_reg.col == p3_cell_reg.col) && !p3_cell_reg.fr;

    // ---------------------------------------------------------------
    // Stage 1: resolve upper entry, form friction sums
    // ---------------------------------------------------------------
    always_comb begin
        if (v2_reg && (p2_cell_reg.col == p1_cell_reg.col)) begin
            up_f_s1 = p2_cell_reg.f;
        end else if (v3_reg && (p3_cell_reg.col == p1_cell_reg.col)) begin
            up_f_s1 = p3_cell_reg.f;
        end else if (v4_reg && (p4_cell_reg.col == p1_cell_reg.col)) begin
            up_f_s1 = p4_cell_reg.f;
        end else if (p1_hit_reg) begin
            up_f_s1 = p1_capf_reg;
        end else begin
            up_f_s1 = rd_q_reg[DIST_W +: FRIC_W];
        end
        if (p1_hit_reg) begin
            up_s1 = p1_cap_reg;
        end else begin
            up_s1.d = rd_q_reg[DIST_W-1:0];
            up_s1.v = rd_q_reg[MEM_W-1];
        end
        // no row above on the first row
        if (p1_cell_reg.fr) begin
            up_f_s1 = '0;
            up_s1   = '0;
        end
    end

    assign su_s1 = {p1_cell_reg.f[FRIC_W-1], p1_cell_reg.f} + {up_f_s1[FRIC_W-1], up_f_s1};
    assign sd_s1 = {p1_cell_reg.f[FRIC_W-1], p1_cell_reg.f}
                 + {lastupf_reg[FRIC_W-1], lastupf_reg};

    // ---------------------------------------------------------------
    // Stage 2: edge multiplies (a magnitude of 2^32 is a plain shift)
    // ---------------------------------------------------------------
    always_comb begin
        prl_s2.neg = p2_sml_reg.neg;
        prl_s2.p   = p2_sml_reg.mag[FRIC_W] ? {step_x_reg, {STEP_W{1'b0}}}
                   : PROD_W'(p2_sml_reg.mag[FRIC_W-1:0]) * PROD_W'(step_x_reg);
        pru_s2.neg = p2_smu_reg.neg;
        pru_s2.p   = p2_smu_reg.mag[FRIC_W] ? {step_y_reg, {STEP_W{1'b0}}}
                   : PROD_W'(p2_smu_reg.mag[FRIC_W-1:0]) * PROD_W'(step_y_reg);
        prd_s2.neg = p2_smd_reg.neg;
        prd_s2.p   = p2_smd_reg.mag[FRIC_W] ? {step_diag_reg, {STEP_W{1'b0}}}
                   : PROD_W'(p2_smd_reg.mag[FRIC_W-1:0]) * PROD_W'(step_diag_reg);
    end

    // ---------------------------------------------------------------
    // Stage 3: drop fraction bits, clamp, grid-mode override
    // ---------------------------------------------------------------
    function automatic cost_t scale_cost(input prod_t pr, input logic grid,
                                         input logic [STEP_W-1:0] step);
        logic [PROD_W-1:0] e;
        cost_t             c;
        e = pr.p >> FRAC_BITS;
        if (grid) begin
            c.neg = 1'b0;
            c.mag = {{(DIST_W + 1 - STEP_W){1'b0}}, step};
        end else begin
            c.neg = pr.neg;
            c.mag = (|e[PROD_W-1:DIST_W]) ? {1'b1, {DIST_W{1'b0}}} : {1'b0, e[DIST_W-1:0]};
        end
        return c;
    endfunction

    assign cl_s3 = scale_cost(p3_prl_reg, grid_reg, step_x_reg);
    assign cu_s3 = scale_cost(p3_pru_reg, grid_reg, step_y_reg);
    assign cd_s3 = scale_cost(p3_prd_reg, grid_reg, step_diag_reg);

    // ---------------------------------------------------------------
    // Stage 4: neighbour candidates and minimum
    // ---------------------------------------------------------------
    assign col_nz = (p4_cell_reg.col != '0);

    always_comb begin
        cp.ok = p4_cell_reg.pv;
        cp.d  = p4_cell_reg.pd;
        cl.ok = p4_cell_reg.fv && col_nz && left_v_reg;
        cl.d  = cand_dist(left_d_reg, p4_cl_reg);
        cu.ok = p4_cell_reg.fv && !p4_cell_reg.fr && p4_up_reg.v;
        cu.d  = cand_dist(p4_up_reg.d, p4_cu_reg);
        cd.ok = p4_cell_reg.fv && !p4_cell_reg.fr && col_nz && diag_v_reg;
        cd.d  = cand_dist(diag_d_reg, p4_cd_reg);
        cbest = cand_min(cand_min(cp, cl), cand_min(cu, cd));
    end

    assign wr_best   = cbest.ok ? cbest.d : '0;
    assign wr_usable = cbest.ok && p4_cell_reg.fv;

    // ---------------------------------------------------------------
    // Valid bits
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v1_reg       <= acc;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            m_tvalid_reg <= v4_reg;
        end
    end

    // Neighbour registers: left cell, upper-left cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lastupf_reg <= '0;
            left_d_reg  <= '0;
            left_v_reg  <= 1'b0;
            diag_d_reg  <= '0;
            diag_v_reg  <= 1'b0;
        end else begin
            if (en && v1_reg) begin
                lastupf_reg <= up_f_s1;
            end
            if (wr_en) begin
                left_d_reg <= wr_best;
                left_v_reg <= wr_usable;
                diag_d_reg <= p4_up_reg.d;
                diag_v_reg <= p4_up_reg.v;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_cell_reg <= cell_in;
            p1_sl_reg   <= sl_in;
            p1_hit_reg  <= cap_acc;
            p1_cap_reg  <= wr_up;
            p1_capf_reg <= p4_cell_reg.f;

            p2_cell_reg <= p1_cell_reg;
            p2_up_reg   <= cap1 ? wr_up : up_s1;
            p2_sml_reg  <= to_smag(p1_sl_reg);
            p2_smu_reg  <= to_smag(su_s1);
            p2_smd_reg  <= to_smag(sd_s1);

            p3_cell_reg <= p2_cell_reg;
            p3_up_reg   <= cap2 ? wr_up : p2_up_reg;
            p3_prl_reg  <= prl_s2;
            p3_pru_reg  <= pru_s2;
            p3_prd_reg  <= prd_s2;

            p4_cell_reg <= p3_cell_reg;
            p4_up_reg   <= cap3 ? wr_up : p3_up_reg;
            p4_cl_reg   <= cl_s3;
            p4_cu_reg   <= cu_s3;
            p4_cd_reg   <= cd_s3;

            m_tdata_reg <= {{(M_TDATA_W - M_USED_W){1'b0}}, p4_cell_reg.neg, cbest.ok,
                            wr_best};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/rcds_checker.sv @@
module rcds_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rcds_pkg::M_TDATA_W-1:0]  m_tdata
);
    import rcds_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // a held result freezes the pipeline, so no cell may enter
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // unknown distance reads as zero
    a_unknown_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_NV_BIT] |-> (m_tdata[DIST_W-1:0] == '0))
        else $error("unknown distance not zero");

    // pad bits above the result fields are zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:M_USED_W] == '0))
        else $error("result pad bits set");

endmodule

bind raster_cost_distance_sweep_core rcds_checker u_rcds_checker (.*);

@@ verif/sweep_checker.sv @@
`timescale 1ns / 1ps

// Watches the cell, result and register channels of the sweep core, keeps its own copy
// of the line store and neighbour registers, and checks every result transfer in order.
module sweep_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rcds_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rcds_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rcds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcds_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              pending,
    output int                              checked
);
    import rcds_pkg::*;

    localparam int LINE_DEPTH = MAX_COLS_DEF;
    localparam int LINE_IDX_W = $clog2(LINE_DEPTH);
    localparam int FRAC       = FRAC_BITS_DEF;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              known;
        logic              neg_seen;
    } cell_result_t;

    // register mirror
    logic [COLS_W-1:0] row_len;
    logic [STEP_W-1:0] step_h;
    logic [STEP_W-1:0] step_v;
    logic [STEP_W-1:0] step_d;
    logic              grid;
    logic [FRIC_W-1:0] target;

    // row above plus left and upper-left neighbours
    logic [DIST_W-1:0] line_dist [LINE_DEPTH];
    logic [FRIC_W-1:0] line_fric [LINE_DEPTH];
    logic              line_ok   [LINE_DEPTH];
    logic [DIST_W-1:0] left_d;
    logic [FRIC_W-1:0] left_f;
    logic              left_ok;
    logic [DIST_W-1:0] diag_d;
    logic [FRIC_W-1:0] diag_f;
    logic              diag_ok;
    int unsigned       col_pos;
    logic              top_row;

    cell_result_t expected_dists [$];

    // neighbour distance plus the cost of the step to it, clamped to [0, DIST_MAX]
    function automatic logic [DIST_W-1:0] path_cost(input logic [DIST_W-1:0] d,
                                                    input logic [FRIC_W-1:0] fa,
                                                    input logic [FRIC_W-1:0] fb,
                                                    input logic [STEP_W-1:0] step);
        logic [FRIC_W:0]        fsum;
        logic [FRIC_W:0]        mag;
        logic [FRIC_W+STEP_W:0] prod;
        logic [FRIC_W+STEP_W:0] scaled;
        logic [DIST_W:0]        cost;
        logic [DIST_W+1:0]      total;
        logic                   downhill;
        cost     = '0;
        downhill = 1'b0;
        if (grid) begin
            cost[STEP_W-1:0] = step;
        end else begin
            fsum     = {fa[FRIC_W-1], fa} + {fb[FRIC_W-1], fb};
            downhill = fsum[FRIC_W];
            mag      = downhill ? -fsum : fsum;
            prod     = mag * step;
            // truncating the magnitude rounds toward zero
            scaled   = prod >> FRAC;
            cost     = scaled[DIST_W:0];
        end
        if (downhill) begin
            return (cost > {1'b0, d}) ? '0 : d - cost[DIST_W-1:0];
        end
        total = {2'b00, d} + {1'b0, cost};
        return (total > {2'b00, DIST_MAX}) ? DIST_MAX : total[DIST_W-1:0];
    endfunction

    // one cell through the sweep: expected result, state moved on
    function automatic cell_result_t sweep_cell(input logic [FRIC_W-1:0] fric,
                                                input logic              fok,
                                                input logic [DIST_W-1:0] prior,
                                                input logic              pok,
                                                input logic              fstart);
        logic [FRIC_W-1:0] f;
        logic [DIST_W-1:0] up_d;
        logic [FRIC_W-1:0] up_f;
        logic              up_ok;
        logic [DIST_W-1:0] best;
        logic              have;
        logic [DIST_W-1:0] cand    [4];
        logic              cand_ok [4];
        int unsigned       eff_cols;
        int unsigned       col;
        logic [LINE_IDX_W-1:0] idx;
        cell_result_t      r;

        eff_cols = (row_len == 0) ? 1 : (row_len > LINE_DEPTH) ? LINE_DEPTH : row_len;
        if (fstart) begin
            col_pos = 0;
            top_row = 1'b1;
        end
        col = (col_pos >= LINE_DEPTH) ? 0 : col_pos;
        idx = col[LINE_IDX_W-1:0];

        up_d  = '0;
        up_f  = '0;
        up_ok = 1'b0;
        if (!top_row) begin
            up_d  = line_dist[idx];
            up_f  = line_fric[idx];
            up_ok = line_ok[idx];
        end

        f          = fric;
        best       = '0;
        have       = 1'b0;
        r.neg_seen = 1'b0;
        if (fok) begin
            if (f == target) begin
                f = '0;
            end
            r.neg_seen = !grid && f[FRIC_W-1];
            cand_ok[0] = pok;
            cand[0]    = prior;
            cand_ok[1] = (col > 0) && left_ok;
            cand[1]    = path_cost(left_d, f, left_f, step_h);
            cand_ok[2] = !top_row && up_ok;
            cand[2]    = path_cost(up_d, f, up_f, step_v);
            cand_ok[3] = !top_row && (col > 0) && diag_ok;
            cand[3]    = path_cost(diag_d, f, diag_f, step_d);
            for (int i = 0; i < 4; i++) begin
                if (cand_ok[i] && (!have || cand[i] < best)) begin
                    best = cand[i];
                    have = 1'b1;
                end
            end
        end else begin
            // no-data cell: prior passes straight through
            have = pok;
            best = pok ? prior : '0;
        end
        if (!have) begin
            best = '0;
        end

        // old upper entry becomes the next cell's upper-left
        diag_d         = up_d;
        diag_f         = up_f;
        diag_ok        = up_ok;
        line_dist[idx] = best;
        line_fric[idx] = f;
        line_ok[idx]   = have && fok;
        left_d         = best;
        left_f         = f;
        left_ok        = have && fok;

        if (col + 1 >= eff_cols) begin
            col_pos = 0;
            top_row = 1'b0;
        end else begin
            col_pos = col + 1;
        end

        r.distance = best;
        r.known    = have;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        cell_result_t got;
        cell_result_t want;
        if (!aresetn) begin
            row_len    = COLUMNS_RST;
            step_h     = STEP_X_RST;
            step_v     = STEP_Y_RST;
            step_d     = STEP_DIAG_RST;
            grid       = 1'b0;
            target     = '0;
            left_d     = '0;
            left_f     = '0;
            left_ok    = 1'b0;
            diag_d     = '0;
            diag_f     = '0;
            diag_ok    = 1'b0;
            col_pos    = 0;
            top_row    = 1'b1;
            mismatches = 0;
            checked    = 0;
            expected_dists.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COLUMNS:     row_len = cfg_data[COLS_W-1:0];
                    CFG_STEP_X:      step_h  = cfg_data[STEP_W-1:0];
                    CFG_STEP_Y:      step_v  = cfg_data[STEP_W-1:0];
                    CFG_STEP_DIAG:   step_d  = cfg_data[STEP_W-1:0];
                    CFG_GRID_MODE:   grid    = cfg_data[0];
                    CFG_TARGET_CODE: target  = cfg_data[FRIC_W-1:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest expectation
            if (m_tvalid && m_tready) begin
                got.distance = m_tdata[DIST_W-1:0];
                got.known    = m_tdata[M_NV_BIT];
                got.neg_seen = m_tdata[M_NEG_BIT];
                if (expected_dists.size() == 0) begin
                    $display("%0t: unexpected result, new_dist %h new_valid %0b neg %0b",
                             $time, got.distance, got.known, got.neg_seen);
                    mismatches++;
                end else begin
                    want = expected_dists.pop_front();
                    checked++;
                    if (got.distance !== want.distance) begin
                        $display("%0t: new_dist expected %h, got %h",
                                 $time, want.distance, got.distance);
                        mismatches++;
                    end
                    if (got.known !== want.known) begin
                        $display("%0t: new_valid expected %0b, got %0b",
                                 $time, want.known, got.known);
                        mismatches++;
                    end
                    if (got.neg_seen !== want.neg_seen) begin
                        $display("%0t: neg_friction expected %0b, got %0b",
                                 $time, want.neg_seen, got.neg_seen);
                        mismatches++;
                    end
                end
            end

            // cell transfer
            if (s_tvalid && s_tready) begin
                expected_dists.push_back(sweep_cell(s_tdata[FRIC_W-1:0], s_tdata[S_FV_BIT],
                                                    s_tdata[S_PD_LSB +: DIST_W],
                                                    s_tdata[S_PV_BIT], s_tuser[0]));
            end
        end
        pending = expected_dists.size();
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import rcds_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          mismatches;
    int          pending;
    int          checked;
    int          idle_pct = 0;
    int          cells_sent = 0;
    int          settings_used = 0;
    int          cycle_count = 0;
    int unsigned live_cols = COLUMNS_RST;
    bit          force_start = 1'b0;
    logic [FRIC_W-1:0] target_now = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    raster_cost_distance_sweep_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sweep_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle limit, %0d results outstanding", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result back-pressure in bursts of random length
    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // one cell transfer, optionally after a gap; tvalid stays high afterwards
    task automatic send_cell(input logic [FRIC_W-1:0] fric, input logic fok,
                             input logic [DIST_W-1:0] prior, input logic pok,
                             input logic fstart);
        logic [S_TDATA_W-1:0] word;
        word                       = '0;
        word[FRIC_W-1:0]           = fric;
        word[S_FV_BIT]             = fok;
        word[S_PD_LSB +: DIST_W]   = prior;
        word[S_PV_BIT]             = pok;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= fstart;
        do @(posedge aclk); while (!s_tready);
        cells_sent++;
    endtask

    // random cell: mostly plain positive frictions, with targets, negatives and extremes
    task automatic random_cell();
        logic [FRIC_W-1:0] fric;
        logic [DIST_W-1:0] prior;
        logic              start;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            fric = $urandom_range(0, 4 << 16);
        end else if (r < 63) begin
            fric = '0;
        end else if (r < 70) begin
            fric = target_now;
        end else if (r < 80) begin
            fric = 32'd0 - $urandom_range(0, 2 << 16);
        end else if (r < 90) begin
            fric = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0:       fric = 32'h7FFF_FFFF;
                1:       fric = 32'h8000_0000;
                2:       fric = 32'hFFFF_FFFF;
                default: fric = 32'h0000_0001;
            endcase
        end
        r = $urandom_range(0, 9);
        if (r < 5) begin
            prior = DIST_W'($urandom_range(0, 1 << 22));
        end else if (r < 8) begin
            prior = DIST_W'({$urandom, $urandom});
        end else if (r == 8) begin
            prior = '0;
        end else begin
            prior = DIST_MAX;
        end
        start       = force_start || ($urandom_range(0, 149) == 0);
        force_start = 1'b0;
        send_cell(fric, $urandom_range(0, 9) != 0, prior, $urandom_range(0, 7) == 0, start);
    endtask

    // lower tvalid and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // register write; cfg_valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // full register set; a wider row forces a new frame so no unwritten entry is read
    task automatic configure(input logic [COLS_W-1:0] cols, input logic [STEP_W-1:0] sx,
                             input logic [STEP_W-1:0] sy, input logic [STEP_W-1:0] sd,
                             input logic grid, input logic [FRIC_W-1:0] tgt);
        int unsigned eff;
        write_reg(CFG_COLUMNS, CFG_DATA_W'(cols));
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
        write_reg(CFG_STEP_DIAG, sd);
        write_reg(CFG_GRID_MODE, CFG_DATA_W'(grid));
        write_reg(CFG_TARGET_CODE, tgt);
        cfg_valid <= 1'b0;
        eff = (cols == 0) ? 1 : (cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cols;
        if (eff > live_cols) begin
            force_start = 1'b1;
        end
        live_cols  = eff;
        target_now = tgt;
        settings_used++;
    endtask

    initial begin
        logic [COLS_W-1:0] cols;
        logic [STEP_W-1:0] sx, sy, sd;
        logic              grid;
        logic [FRIC_W-1:0] tgt;
        int                n;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: three-cell rows in cost mode, target friction 3.0
        idle_pct = 20;
        configure(13'd3, 32'd65536, 32'd65536, 32'd92682, 1'b0, 32'h0003_0000);
        send_cell(32'h0001_0000, 1'b1, 48'd0, 1'b1, 1'b1);            // seeded corner
        send_cell(32'h0002_0000, 1'b1, 48'd0, 1'b0, 1'b0);            // left only
        send_cell(32'h0003_0000, 1'b1, 48'd0, 1'b0, 1'b0);            // target cell
        send_cell(32'h7FFF_FFFF, 1'b1, 48'd0, 1'b0, 1'b0);            // first column
        send_cell(32'h0001_0000, 1'b0, 48'h1234_5678_9ABC, 1'b1, 1'b0); // no-data
        send_cell(32'hFFFF_0000, 1'b1, 48'd0, 1'b0, 1'b0);            // negative friction
        send_cell(32'h8000_0000, 1'b1, DIST_MAX, 1'b1, 1'b0);
        send_cell(32'h0000_0000, 1'b1, 48'd0, 1'b0, 1'b0);            // up is unusable
        send_cell(32'h0001_0000, 1'b0, 48'd0, 1'b0, 1'b0);            // unknown result
        send_cell(32'h0001_0000, 1'b1, DIST_MAX, 1'b0, 1'b1);         // frame restart
        send_cell(32'h0001_0000, 1'b1, DIST_MAX, 1'b1, 1'b0);
        send_cell(32'hFFFF_FFFF, 1'b1, 48'h0000_0001_0000, 1'b1, 1'b0);
        settle();

        // grid mode, zero columns acting as one, steps at maximum
        configure(13'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
        send_cell(32'h8000_0000, 1'b1, DIST_MAX - 5, 1'b1, 1'b1);
        send_cell(32'hFFFF_0000, 1'b1, 48'd0, 1'b0, 1'b0);
        send_cell(32'h0000_0000, 1'b1, 48'd0, 1'b0, 1'b0);
        settle();

        // four-cell rows, then the row shrinks to two part way through
        configure(13'd4, 32'd65536, 32'd0, 32'd131072, 1'b0, 32'd0);
        for (int i = 0; i < 6; i++) begin
            send_cell(32'h0001_0000 * (i + 1), 1'b1, 48'd0, i == 0, i == 0);
        end
        settle();
        configure(13'd2, 32'd65536, 32'd0, 32'd131072, 1'b0, 32'd0);
        for (int i = 0; i < 3; i++) begin
            send_cell(32'h0000_8000, 1'b1, 48'd0, 1'b0, 1'b0);
        end
        settle();

        // random phases, each with its own register setting and idling rate
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 9))
                0:       cols = 13'd1;
                1:       cols = 13'd2;
                2, 3, 4, 5: cols = COLS_W'($urandom_range(3, 12));
                9:       cols = 13'd0;
                default: cols = COLS_W'($urandom_range(13, 40));
            endcase
            sx   = ($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(0, 1 << 18);
            sy   = ($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(0, 1 << 18);
            sd   = ($urandom_range(0, 6) == 0) ? 32'd92682 : $urandom_range(0, 1 << 18);
            grid = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0, 1:    tgt = '0;
                2, 3:    tgt = $urandom_range(0, 4 << 16);
                default: tgt = $urandom;
            endcase
            n = $urandom_range(30, 60);
            case (ph)
                0: begin sx = '0; sy = '0; sd = '0; grid = 1'b0; end
                1: begin sx = '1; sy = '1; sd = '1; grid = 1'b0; end
                2: begin grid = 1'b1; tgt = 32'h8000_0000; end
                3: begin grid = 1'b0; tgt = 32'h7FFF_FFFF; end
                4: begin cols = 13'd4096; n = 40; end
                5: begin grid = 1'b1; sx = '1; sy = '1; sd = '1; end
                default: ;
            endcase
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 30;
            endcase
            configure(cols, sx, sy, sd, grid, tgt);
            repeat (n) random_cell();
            settle();
        end

        // oversized column count acting as the full line, part of one row
        idle_pct = 10;
        configure(13'd8191, 32'd65536, 32'd65536, 32'd92682, 1'b0, 32'd0);
        repeat (40) random_cell();
        settle();

        // closing stretch without any idling
        idle_pct = 0;
        configure(COLS_W'($urandom_range(3, 16)), 32'd65536, 32'd65536, 32'd92682, 1'b0,
                  32'h0001_0000);
        repeat (60) random_cell();
        settle();

        $display("%0d cells sent, %0d results checked across %0d register settings",
                 cells_sent, checked, settings_used);
        $display("covered cost and grid mode, rows of 0 to 8191 columns, extreme steps");
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
